@@ src/bhrb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and defaults for the banked history ring buffer.
package bhrb_pkg;

  localparam int BANKS_DEF        = 2;
  localparam int DEPTH_DEF        = 128;
  localparam int RECORD_WIDTH_DEF = 64;

  localparam int POS_W       = 7;
  localparam int DATA_W      = 64;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  localparam logic [1:0] MODE_WRITE    = 2'd0;
  localparam logic [1:0] MODE_READ_FWD = 2'd1;
  localparam logic [1:0] MODE_READ_BWD = 2'd2;
  localparam logic [1:0] MODE_CLEAR    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             failed;
    logic             rd_ok;
    logic [POS_W-1:0] next_position;
    logic [POS_W-1:0] write_pointer;
    logic             full_flag;
  } resp_t;

endpackage

@@ src/bhrb_ram.sv @@
`timescale 1ns / 1ps
// Single-port record memory with a registered read.
module bhrb_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/bhrb_ctrl.sv @@
`timescale 1ns / 1ps
// Bank pointer table, request decode and memory address generation.
module bhrb_ctrl #(
  parameter int BANKS        = bhrb_pkg::BANKS_DEF,
  parameter int DEPTH        = bhrb_pkg::DEPTH_DEF,
  parameter int RECORD_WIDTH = bhrb_pkg::RECORD_WIDTH_DEF,
  parameter int ADDR_W       = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [1:0]                   in_mode,
  input  logic [1:0]                   in_bank,
  input  logic                         in_use_default_start,
  input  logic [bhrb_pkg::POS_W-1:0]   in_position,
  input  logic [bhrb_pkg::DATA_W-1:0]  in_write_data,
  output logic                         mem_we,
  output logic                         mem_re,
  output logic [ADDR_W-1:0]            mem_addr,
  output logic [RECORD_WIDTH-1:0]      mem_wdata,
  output bhrb_pkg::resp_t              resp
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int CW    = ((PTR_W > bhrb_pkg::POS_W) ? PTR_W : bhrb_pkg::POS_W) + 1;
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
  localparam logic [CW-1:0]    DEPTH_X = CW'(DEPTH);

  logic [PTR_W-1:0] ptr_r  [BANKS];
  logic             full_r [BANKS];

  logic             bank_ok;
  logic [BW-1:0]    bidx;
  logic [PTR_W-1:0] wp;
  logic             full;
  logic [PTR_W-1:0] wp_nxt;
  logic             full_nxt;
  logic [PTR_W-1:0] slot;
  logic [PTR_W-1:0] nxt;
  logic             ok;
  logic             fwd;
  logic [CW-1:0]    pos_x;
  logic [CW-1:0]    wp_x;
  logic [CW-1:0]    wpn_x;
  logic [CW-1:0]    nxt_x;

  assign bank_ok = {1'b0, in_bank} < 3'(BANKS);
  assign bidx    = bank_ok ? in_bank[BW-1:0] : '0;
  assign wp      = ptr_r[bidx];
  assign full    = full_r[bidx];
  assign pos_x   = CW'(in_position);
  assign wp_x    = CW'(wp);
  assign fwd     = (in_mode == bhrb_pkg::MODE_READ_FWD);

  always_comb begin
    resp     = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    slot     = '0;
    nxt      = '0;
    ok       = 1'b1;
    wp_nxt   = wp;
    full_nxt = full;
    wpn_x    = '0;
    nxt_x    = '0;
    if (!bank_ok) begin
      resp.failed = 1'b1;
    end else begin
      unique case (in_mode) inside
        bhrb_pkg::MODE_WRITE: begin
          mem_we   = accept;
          slot     = wp;
          wp_nxt   = (wp == LAST) ? '0 : wp + 1'b1;
          full_nxt = full | (wp == LAST);
        end
        bhrb_pkg::MODE_CLEAR: begin
          wp_nxt   = '0;
          full_nxt = 1'b0;
        end
        bhrb_pkg::MODE_READ_FWD, bhrb_pkg::MODE_READ_BWD: begin
          if (in_use_default_start) begin
            if (full) begin
              slot = fwd ? wp : ((wp == '0) ? LAST : wp - 1'b1);
            end else if (wp == '0) begin
              ok = 1'b0;
            end else begin
              slot = fwd ? '0 : wp - 1'b1;
            end
          end else begin
            slot = pos_x[PTR_W-1:0];
            if (full) begin
              ok = !((pos_x >= DEPTH_X) || (pos_x == wp_x));
            end else begin
              ok = pos_x < wp_x;
            end
          end
          if (fwd) begin
            nxt = (slot == LAST) ? '0 : slot + 1'b1;
          end else begin
            nxt = (slot == '0) ? LAST : slot - 1'b1;
          end
          nxt_x = CW'(nxt);
          resp.failed = !ok;
          if (ok) begin
            mem_re             = accept;
            resp.rd_ok         = 1'b1;
            resp.next_position = nxt_x[bhrb_pkg::POS_W-1:0];
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
      wpn_x              = CW'(wp_nxt);
      resp.write_pointer = wpn_x[bhrb_pkg::POS_W-1:0];
      resp.full_flag     = full_nxt;
    end
  end

  assign mem_addr  = ADDR_W'(bidx) * ADDR_W'(DEPTH) + ADDR_W'(slot);
  assign mem_wdata = in_write_data[RECORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BANKS; i++) begin
        ptr_r[i]  <= '0;
        full_r[i] <= 1'b0;
      end
    end else if (accept && bank_ok) begin
      ptr_r[bidx]  <= wp_nxt;
      full_r[bidx] <= full_nxt;
    end
  end

endmodule

@@ src/banked_history_ring_buffer_core.sv @@
`timescale 1ns / 1ps
// Throughput: one request per cycle while the result side keeps taking results.
// The record memory read port is registered, so the output register loads from the registered read data.
// Reset clears every bank's write pointer and full flag; records are not cleared.
// Top level of the banked history ring buffer with stream handshakes.
module banked_history_ring_buffer_core #(
  parameter int BANKS        = bhrb_pkg::BANKS_DEF,
  parameter int DEPTH        = bhrb_pkg::DEPTH_DEF,
  parameter int RECORD_WIDTH = bhrb_pkg::RECORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mode[1:0], bank[3:2], use_default_start[4], position[11:5], write_data[75:12], zero pad
  input  logic [bhrb_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // failed[0], read_data[64:1], next_position[71:65], write_pointer[78:72], full_flag[79]
  output logic [bhrb_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int ADDR_W = (BANKS * DEPTH > 1) ? $clog2(BANKS * DEPTH) : 1;

  bhrb_pkg::state_t state_r, state_nxt;
  bhrb_pkg::resp_t  resp, resp_r;

  logic                               accept;
  logic                               load;
  logic                               mem_we;
  logic                               mem_re;
  logic [ADDR_W-1:0]                  mem_addr;
  logic [RECORD_WIDTH-1:0]            mem_wdata;
  logic [RECORD_WIDTH-1:0]            mem_rdata;
  logic [bhrb_pkg::DATA_W-1:0]        rd_data;
  logic                               out_valid_r;
  logic [bhrb_pkg::OUT_TDATA_W-1:0]   out_data_r;

  bhrb_ctrl #(
    .BANKS        (BANKS),
    .DEPTH        (DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .accept               (accept),
    .in_mode              (in_tdata[1:0]),
    .in_bank              (in_tdata[3:2]),
    .in_use_default_start (in_tdata[4]),
    .in_position          (in_tdata[11:5]),
    .in_write_data        (in_tdata[75:12]),
    .mem_we               (mem_we),
    .mem_re               (mem_re),
    .mem_addr             (mem_addr),
    .mem_wdata            (mem_wdata),
    .resp                 (resp)
  );

  bhrb_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (RECORD_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bhrb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bhrb_pkg::ST_RESP;
        end
      end
      bhrb_pkg::ST_RESP: begin
        if (load && !accept) begin
          state_nxt = bhrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bhrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    load      = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      bhrb_pkg::ST_IDLE: begin
        in_tready = rst_n;
      end
      bhrb_pkg::ST_RESP: begin
        load      = !out_valid_r || out_tready;
        in_tready = load && rst_n;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept  = in_tvalid && in_tready;
  assign rd_data = resp_r.rd_ok ? bhrb_pkg::DATA_W'(mem_rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhrb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp_r <= resp;
    end
    if (load) begin
      out_data_r <= {resp_r.full_flag, resp_r.write_pointer, resp_r.next_position,
                     rd_data, resp_r.failed};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[64:1] == '0 && out_tdata[71:65] == '0))
    else $error("failed result carries read data or a next position");

  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == bhrb_pkg::ST_RESP))
    else $error("accepted request did not enter the response state");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == bhrb_pkg::ST_RESP))
    else $error("result became valid without a pending request");
`endif

endmodule

@@ tb/sv/tb_banked_history_ring_buffer_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the banked history ring buffer with in-order result check.
module tb_banked_history_ring_buffer_core;

  localparam int BANKS        = bhrb_pkg::BANKS_DEF;
  localparam int DEPTH        = bhrb_pkg::DEPTH_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEM_TARGET  = 1750;

  typedef struct {
    logic [1:0]                  mode;
    logic [1:0]                  bank;
    logic                        dflt;
    logic [bhrb_pkg::POS_W-1:0]  pos;
    logic [bhrb_pkg::DATA_W-1:0] wdata;
  } access_t;

  typedef struct {
    logic                        failed;
    logic [bhrb_pkg::DATA_W-1:0] read_data;
    logic [bhrb_pkg::POS_W-1:0]  next_pos;
    logic [bhrb_pkg::POS_W-1:0]  wptr;
    logic                        full;
  } outcome_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [bhrb_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [bhrb_pkg::OUT_TDATA_W-1:0] out_tdata;

  access_t  access_requests_q[$];
  outcome_t history_results_q[$];
  access_t  in_flight;

  logic [bhrb_pkg::DATA_W-1:0] shadow_records [BANKS][DEPTH];
  int                          shadow_wp [BANKS];
  logic                        shadow_full [BANKS];
  int                          plan_wp [BANKS];
  logic                        plan_full [BANKS];

  int mismatch_count = 0;
  int accepted_count = 0;
  int total_items = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  banked_history_ring_buffer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [bhrb_pkg::DATA_W-1:0] rand_record();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic push_access(logic [1:0] mode, logic [1:0] bank, logic dflt,
                             logic [bhrb_pkg::POS_W-1:0] pos,
                             logic [bhrb_pkg::DATA_W-1:0] wdata);
    access_t a;
    a.mode  = mode;
    a.bank  = bank;
    a.dflt  = dflt;
    a.pos   = pos;
    a.wdata = wdata;
    access_requests_q.push_back(a);
    if (bank < BANKS) begin
      if (mode == bhrb_pkg::MODE_WRITE) begin
        if (plan_wp[bank] == DEPTH - 1) begin
          plan_wp[bank]   = 0;
          plan_full[bank] = 1'b1;
        end else begin
          plan_wp[bank]++;
        end
      end else if (mode == bhrb_pkg::MODE_CLEAR) begin
        plan_wp[bank]   = 0;
        plan_full[bank] = 1'b0;
      end
    end
  endtask

  function automatic outcome_t history_access(access_t a);
    outcome_t r;
    int       b;
    int       wp;
    int       slot;
    logic     full;
    logic     ok;
    r = '{default: '0};
    if (a.bank >= BANKS) begin
      r.failed = 1'b1;
      return r;
    end
    b    = int'(a.bank);
    wp   = shadow_wp[b];
    full = shadow_full[b];
    case (a.mode)
      bhrb_pkg::MODE_WRITE: begin
        shadow_records[b][wp] = a.wdata;
        if (wp == DEPTH - 1) begin
          wp             = 0;
          shadow_full[b] = 1'b1;
        end else begin
          wp++;
        end
        shadow_wp[b] = wp;
        r.wptr       = bhrb_pkg::POS_W'(wp);
        r.full       = shadow_full[b];
      end
      bhrb_pkg::MODE_CLEAR: begin
        shadow_wp[b]   = 0;
        shadow_full[b] = 1'b0;
      end
      default: begin
        ok   = 1'b1;
        slot = 0;
        if (a.dflt) begin
          if (full) begin
            slot = (a.mode == bhrb_pkg::MODE_READ_FWD) ? wp
                                                       : (wp == 0 ? DEPTH - 1 : wp - 1);
          end else if (wp == 0) begin
            ok = 1'b0;
          end else begin
            slot = (a.mode == bhrb_pkg::MODE_READ_FWD) ? 0 : wp - 1;
          end
        end else begin
          slot = int'(a.pos);
          ok   = full ? (slot != wp) : (slot < wp);
        end
        r.wptr = bhrb_pkg::POS_W'(wp);
        r.full = full;
        if (ok) begin
          r.read_data = shadow_records[b][slot];
          if (a.mode == bhrb_pkg::MODE_READ_FWD) begin
            r.next_pos = bhrb_pkg::POS_W'((slot == DEPTH - 1) ? 0 : slot + 1);
          end else begin
            r.next_pos = bhrb_pkg::POS_W'((slot == 0) ? DEPTH - 1 : slot - 1);
          end
        end else begin
          r.failed = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [bhrb_pkg::DATA_W-1:0] got,
                             logic [bhrb_pkg::DATA_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        history_results_q.push_back(history_access(in_flight));
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || access_requests_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          in_flight = access_requests_q.pop_front();
          in_tdata  <= {4'b0, in_flight.wdata, in_flight.pos, in_flight.dflt,
                        in_flight.bank, in_flight.mode};
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_phase % 3 != 0);
    endcase
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (history_results_q.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h with no request pending", out_tdata));
      end else begin
        want = history_results_q.pop_front();
        check_field("failed", bhrb_pkg::DATA_W'(out_tdata[0]),
                    bhrb_pkg::DATA_W'(want.failed));
        check_field("read_data", out_tdata[64:1], want.read_data);
        check_field("next_position", bhrb_pkg::DATA_W'(out_tdata[71:65]),
                    bhrb_pkg::DATA_W'(want.next_pos));
        check_field("write_pointer", bhrb_pkg::DATA_W'(out_tdata[78:72]),
                    bhrb_pkg::DATA_W'(want.wptr));
        check_field("full_flag", bhrb_pkg::DATA_W'(out_tdata[79]),
                    bhrb_pkg::DATA_W'(want.full));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL banked_history_ring_buffer_core");
      $finish;
    end
  end

  initial begin
    int               b;
    int               len;
    int               slot;
    int               pick;
    logic             fwd;
    logic [1:0]       m;

    for (int i = 0; i < BANKS; i++) begin
      shadow_wp[i]   = 0;
      shadow_full[i] = 1'b0;
      plan_wp[i]     = 0;
      plan_full[i]   = 1'b0;
    end

    // Directed part: empty banks, small fills, explicit bounds, bad banks and clear.
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd0, 1'b1, 7'd0, '0);
    push_access(bhrb_pkg::MODE_READ_BWD, 2'd0, 1'b1, 7'd127, '0);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd0, 1'b0, 7'd0, '1);
    push_access(bhrb_pkg::MODE_WRITE, 2'd0, 1'b0, 7'd0, '0);
    push_access(bhrb_pkg::MODE_WRITE, 2'd0, 1'b1, 7'd127, '1);
    push_access(bhrb_pkg::MODE_WRITE, 2'd0, 1'b0, 7'd0, 64'hA5A5_5A5A_0F0F_F0F0);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd0, 1'b1, 7'd0, '0);
    push_access(bhrb_pkg::MODE_READ_BWD, 2'd0, 1'b1, 7'd0, '0);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd0, 1'b0, 7'd1, '0);
    push_access(bhrb_pkg::MODE_READ_BWD, 2'd0, 1'b0, 7'd0, '0);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd0, 1'b0, 7'd3, '0);
    push_access(bhrb_pkg::MODE_READ_BWD, 2'd0, 1'b0, 7'd127, '0);
    push_access(bhrb_pkg::MODE_WRITE, 2'd1, 1'b0, 7'd0, 64'h8000_0000_0000_0001);
    push_access(bhrb_pkg::MODE_READ_BWD, 2'd1, 1'b1, 7'd0, '0);
    push_access(bhrb_pkg::MODE_WRITE, 2'd2, 1'b0, 7'd0, '1);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd2, 1'b1, 7'd0, '0);
    push_access(bhrb_pkg::MODE_READ_BWD, 2'd2, 1'b0, 7'd0, '0);
    push_access(bhrb_pkg::MODE_CLEAR, 2'd2, 1'b0, 7'd0, '0);
    push_access(bhrb_pkg::MODE_WRITE, 2'd3, 1'b1, 7'd127, '1);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd3, 1'b0, 7'd64, '0);
    push_access(bhrb_pkg::MODE_CLEAR, 2'd0, 1'b0, 7'd0, '0);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd0, 1'b1, 7'd0, '0);
    push_access(bhrb_pkg::MODE_READ_FWD, 2'd0, 1'b0, 7'd0, '0);
    push_access(bhrb_pkg::MODE_WRITE, 2'd0, 1'b0, 7'd0, 64'h1234_5678_9ABC_DEF0);
    push_access(bhrb_pkg::MODE_READ_BWD, 2'd0, 1'b1, 7'd0, '0);

    // Wrap one bank early so full-bank reads show up throughout the random part.
    for (int i = 0; i < DEPTH + 2; i++) begin
      push_access(bhrb_pkg::MODE_WRITE, 2'd1, 1'($urandom_range(0, 1)),
                  bhrb_pkg::POS_W'($urandom()), rand_record());
    end

    while (access_requests_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      b    = $urandom_range(0, BANKS - 1);
      if (pick < 2) begin
        push_access(bhrb_pkg::MODE_CLEAR, 2'(b), 1'($urandom_range(0, 1)),
                    bhrb_pkg::POS_W'($urandom()), rand_record());
      end else if (pick < 37) begin
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++) begin
          push_access(bhrb_pkg::MODE_WRITE, 2'(b), 1'($urandom_range(0, 1)),
                      bhrb_pkg::POS_W'($urandom()), rand_record());
        end
      end else if (pick < 75) begin
        // Walk from the default start along the returned next positions.
        fwd  = 1'($urandom_range(0, 1));
        m    = fwd ? bhrb_pkg::MODE_READ_FWD : bhrb_pkg::MODE_READ_BWD;
        len  = $urandom_range(1, 20);
        slot = fwd ? (plan_full[b] ? plan_wp[b] : 0) : (plan_wp[b] + DEPTH - 1) % DEPTH;
        push_access(m, 2'(b), 1'b1, bhrb_pkg::POS_W'($urandom()), rand_record());
        for (int k = 1; k < len; k++) begin
          slot = fwd ? (slot + 1) % DEPTH : (slot + DEPTH - 1) % DEPTH;
          push_access(m, 2'(b), 1'b0, bhrb_pkg::POS_W'(slot), rand_record());
        end
      end else begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 1)) begin
            push_access(2'($urandom_range(0, 3)), 2'($urandom_range(BANKS, 3)),
                        1'($urandom_range(0, 1)), bhrb_pkg::POS_W'($urandom()),
                        rand_record());
          end else begin
            push_access(2'($urandom_range(0, 2)), 2'($urandom_range(0, BANKS - 1)),
                        1'($urandom_range(0, 1)), bhrb_pkg::POS_W'($urandom()),
                        rand_record());
          end
        end
      end
    end
    total_items = access_requests_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_items) @(posedge clk);
    while (history_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS banked_history_ring_buffer_core");
    end else begin
      $display("FAIL banked_history_ring_buffer_core");
    end
    $finish;
  end

endmodule
